// ===== rtl/grid_astar_path_search_assert.svh =====
`ifndef GRID_ASTAR_PATH_SEARCH_ASSERT_SVH
`define GRID_ASTAR_PATH_SEARCH_ASSERT_SVH

// same-cycle implication
`define GAP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gap check failed");

// next-cycle implication
`define GAP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gap check failed");

`endif

// ===== rtl/gap_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package gap_pkg;
  localparam int unsigned CellW    = 12;
  localparam int unsigned Cells    = 4096;
  localparam int unsigned PathDep  = 1024;
  localparam int unsigned PathAw   = 10;
  localparam int unsigned CoordW   = 6;
  localparam int unsigned DimW     = 7;
  localparam int unsigned LimW     = 11;
  localparam int unsigned CostW    = 13;
  localparam logic [DimW-1:0] MaxDim = 7'd64;
  localparam logic [LimW-1:0] MaxExp = 11'd1024;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_LIMIT  = 2'd2,
    REG_NONE   = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_CLEAR, S_INIT, S_CHECK, S_NB_RD, S_NB_WR,
    S_SCAN, S_SCAN_END, S_PICK, S_FIN, S_TR_CHK, S_TR_WR
  } state_e;

  typedef struct packed {
    logic              open;
    logic              closed;
    logic [CellW-1:0]  parent;
    logic [CostW-1:0]  g;
    logic [CostW-1:0]  f;
  } node_t;
endpackage
`default_nettype wire

// ===== rtl/gap_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gap_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 4
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]              rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/grid_astar_path_search.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Command-driven grid A* engine. A load and a waypoint read each answer with the
// result strobe done_o, which lasts one cycle and cannot be held off. A search keeps
// busy high through the clearing of all 4096 node words and an init step, then per
// expanded cell a check step, a read step for each of the four neighbours plus a write
// step for each in-grid one, and a scan of all width*height cells through the shared
// node memory, then a check and a write step per traced waypoint.
module grid_astar_path_search
  import gap_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        command_i,
  input  wire logic [11:0]       cell_index_i,
  input  wire logic              cell_blocked_i,
  input  wire logic [15:0]       start_x_i,
  input  wire logic [15:0]       start_y_i,
  input  wire logic [15:0]       goal_x_i,
  input  wire logic [15:0]       goal_y_i,
  input  wire logic [9:0]        path_position_i,
  output logic                   done_o,
  output logic                   goal_reached_o,
  output logic [10:0]            path_length_o,
  output logic [5:0]             waypoint_x_o,
  output logic [5:0]             waypoint_y_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [10:0]       cfg_data_i
);
  state_e state_q, state_d;
  logic [DimW-1:0] cfg_w_q, cfg_h_q;
  logic [LimW-1:0] cfg_lim_q;
  logic [DimW-1:0] w_q, w_d, h_q, h_d;
  logic [LimW-1:0] lim_q, lim_d;
  logic [CoordW-1:0] s_col_q, s_col_d, s_row_q, s_row_d, g_col_q, g_col_d, g_row_q, g_row_d;
  logic [CoordW-1:0] cur_col_q, cur_col_d, cur_row_q, cur_row_d;
  logic [CostW-1:0] cur_g_q, cur_g_d;
  logic [LimW-1:0] closed_n_q, closed_n_d, pc_q, pc_d;
  logic [1:0] k_q, k_d;
  logic [CellW-1:0] clr_q, clr_d, nb_idx_q, nb_idx_d, sc_idx_q, sc_idx_d, p_idx_q, p_idx_d;
  logic [CoordW-1:0] nb_col_q, nb_col_d, nb_row_q, nb_row_d;
  logic [CoordW-1:0] sc_col_q, sc_col_d, sc_row_q, sc_row_d;
  logic [CoordW-1:0] p_col_q, p_col_d, p_row_q, p_row_d;
  logic pv_q, pv_d, bf_q, bf_d, found_q, found_d, rd_ok_q, rd_ok_d, done_q, done_d;
  logic [CellW-1:0] best_idx_q, best_idx_d;
  logic [CoordW-1:0] best_col_q, best_col_d, best_row_q, best_row_d;
  node_t best_q, best_d;
  logic [CoordW-1:0] wx_q, wx_d, wy_q, wy_d;

  logic node_we, blk_we, blk_rd, path_we;
  logic [CellW-1:0] node_waddr, node_raddr, blk_waddr, blk_raddr;
  node_t node_wdata, node_rd;
  logic [PathAw-1:0] path_waddr, path_raddr;
  logic [CellW-1:0] path_wdata, path_rd;
  logic [$bits(node_t)-1:0] node_rd_raw;

  logic [DimW-1:0] sat_w, sat_h;
  logic [CellW-1:0] cur_idx;
  logic [CostW-1:0] cells, ng;
  logic nb_ok, at_goal;
  logic [CoordW:0] hdist;

  function automatic logic [DimW-1:0] sat_dim(input logic [DimW-1:0] v);
    if (v == '0) return DimW'(1);
    if (v > MaxDim) return MaxDim;
    return v;
  endfunction

  function automatic logic [CoordW-1:0] to_cell(input logic [15:0] pix,
                                                input logic [DimW-1:0] dim);
    logic [10:0] c;
    logic [10:0] m;
    c = pix[15:5];
    m = 11'(dim) - 11'd1;
    return (c > m) ? m[CoordW-1:0] : c[CoordW-1:0];
  endfunction

  function automatic logic [CoordW-1:0] absdiff(input logic [CoordW-1:0] a,
                                                input logic [CoordW-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  assign sat_w   = sat_dim(cfg_w_q);
  assign sat_h   = sat_dim(cfg_h_q);
  assign cur_idx = CellW'((CostW'(cur_row_q) * CostW'(w_q)) + CostW'(cur_col_q));
  assign cells   = CostW'(w_q) * CostW'(h_q);
  assign ng      = cur_g_q + CostW'(1);
  assign at_goal = (cur_col_q == g_col_q) && (cur_row_q == g_row_q);
  assign hdist   = (CoordW+1)'(absdiff(nb_col_q, g_col_q)) +
                   (CoordW+1)'(absdiff(nb_row_q, g_row_q));
  assign node_rd = node_t'(node_rd_raw);

  always_comb begin
    case (k_q)
      2'd0:    nb_ok = (DimW'(cur_col_q) + DimW'(1)) < w_q;
      2'd1:    nb_ok = cur_col_q != '0;
      2'd2:    nb_ok = (DimW'(cur_row_q) + DimW'(1)) < h_q;
      default: nb_ok = cur_row_q != '0;
    endcase
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q   <= MaxDim;
      cfg_h_q   <= MaxDim;
      cfg_lim_q <= MaxExp;
    end else if (cfg_valid_i) begin
      case (reg_e'(cfg_index_i))
        REG_WIDTH:  cfg_w_q   <= cfg_data_i[DimW-1:0];
        REG_HEIGHT: cfg_h_q   <= cfg_data_i[DimW-1:0];
        REG_LIMIT:  cfg_lim_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (cmd_e'(command_i))
            CMD_SEARCH: state_d = S_CLEAR;
            CMD_READ:   state_d = S_READ;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_READ:  state_d = S_IDLE;
      S_CLEAR: if (clr_q == CellW'(Cells - 1)) state_d = S_INIT;
      S_INIT:  state_d = S_CHECK;
      S_CHECK: state_d = (closed_n_q < lim_q && !at_goal) ? S_NB_RD : S_FIN;
      S_NB_RD: begin
        if (nb_ok) state_d = S_NB_WR;
        else if (k_q == 2'd3) state_d = S_SCAN;
      end
      S_NB_WR: state_d = (k_q == 2'd3) ? S_SCAN : S_NB_RD;
      S_SCAN:  if (CostW'(sc_idx_q) == cells - CostW'(1)) state_d = S_SCAN_END;
      S_SCAN_END: state_d = S_PICK;
      S_PICK:  state_d = bf_q ? S_CHECK : S_FIN;
      S_FIN:   state_d = S_TR_CHK;
      S_TR_CHK: begin
        if ((cur_col_q != s_col_q || cur_row_q != s_row_q) && pc_q < MaxExp) begin
          state_d = S_TR_WR;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_TR_WR: state_d = S_TR_CHK;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    w_d = w_q; h_d = h_q; lim_d = lim_q;
    s_col_d = s_col_q; s_row_d = s_row_q; g_col_d = g_col_q; g_row_d = g_row_q;
    cur_col_d = cur_col_q; cur_row_d = cur_row_q; cur_g_d = cur_g_q;
    closed_n_d = closed_n_q; pc_d = pc_q; k_d = k_q; clr_d = clr_q;
    nb_idx_d = nb_idx_q; nb_col_d = nb_col_q; nb_row_d = nb_row_q;
    sc_idx_d = sc_idx_q; sc_col_d = sc_col_q; sc_row_d = sc_row_q;
    p_idx_d = sc_idx_q; p_col_d = sc_col_q; p_row_d = sc_row_q;
    pv_d = 1'b0; bf_d = bf_q; found_d = found_q;
    rd_ok_d = rd_ok_q; done_d = 1'b0; wx_d = wx_q; wy_d = wy_q;
    best_idx_d = best_idx_q; best_col_d = best_col_q; best_row_d = best_row_q;
    best_d = best_q;
    node_we = 1'b0; node_waddr = cur_idx; node_wdata = '0; node_raddr = cur_idx;
    blk_we = 1'b0; blk_waddr = cell_index_i; blk_raddr = nb_idx_q;
    path_we = 1'b0; path_waddr = pc_q[PathAw-1:0]; path_wdata = {cur_row_q, cur_col_q};
    path_raddr = PathAw'(pc_q - LimW'(1) - LimW'(path_position_i));

    // scan compare on the word read last cycle
    if (pv_q && node_rd.open && !node_rd.closed && (!bf_q || node_rd.f < best_q.f)) begin
      bf_d = 1'b1;
      best_d = node_rd;
      best_idx_d = p_idx_q;
      best_col_d = p_col_q;
      best_row_d = p_row_q;
    end

    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (cmd_e'(command_i))
            CMD_LOAD: begin
              blk_we = 1'b1;
              done_d = 1'b1;
              wx_d = '0;
              wy_d = '0;
            end
            CMD_SEARCH: begin
              w_d = sat_w;
              h_d = sat_h;
              lim_d = (cfg_lim_q > MaxExp) ? MaxExp : cfg_lim_q;
              s_col_d = to_cell(start_x_i, sat_w);
              s_row_d = to_cell(start_y_i, sat_h);
              g_col_d = to_cell(goal_x_i, sat_w);
              g_row_d = to_cell(goal_y_i, sat_h);
              clr_d = '0;
            end
            CMD_READ: rd_ok_d = LimW'(path_position_i) < pc_q;
            default: begin
              done_d = 1'b1;
              wx_d = '0;
              wy_d = '0;
            end
          endcase
        end
      end
      S_READ: begin
        done_d = 1'b1;
        wx_d = rd_ok_q ? path_rd[CoordW-1:0] : '0;
        wy_d = rd_ok_q ? path_rd[CellW-1:CoordW] : '0;
      end
      S_CLEAR: begin
        node_we = 1'b1;
        node_waddr = clr_q;
        clr_d = clr_q + CellW'(1);
        cur_col_d = s_col_q;
        cur_row_d = s_row_q;
      end
      S_INIT: begin
        node_we = 1'b1;
        node_wdata.closed = 1'b1;
        node_wdata.parent = {s_row_q, s_col_q};
        cur_g_d = '0;
        closed_n_d = LimW'(1);
        pc_d = '0;
      end
      S_CHECK: k_d = '0;
      S_NB_RD: begin
        case (k_q)
          2'd0: begin
            nb_idx_d = cur_idx + CellW'(1);
            nb_col_d = cur_col_q + CoordW'(1); nb_row_d = cur_row_q;
          end
          2'd1: begin
            nb_idx_d = cur_idx - CellW'(1);
            nb_col_d = cur_col_q - CoordW'(1); nb_row_d = cur_row_q;
          end
          2'd2: begin
            nb_idx_d = cur_idx + CellW'(w_q);
            nb_col_d = cur_col_q; nb_row_d = cur_row_q + CoordW'(1);
          end
          default: begin
            nb_idx_d = cur_idx - CellW'(w_q);
            nb_col_d = cur_col_q; nb_row_d = cur_row_q - CoordW'(1);
          end
        endcase
        node_raddr = nb_idx_d;
        blk_raddr = nb_idx_d;
        if (!nb_ok) k_d = k_q + 2'd1;
        sc_idx_d = '0; sc_col_d = '0; sc_row_d = '0; bf_d = 1'b0;
      end
      S_NB_WR: begin
        node_waddr = nb_idx_q;
        node_wdata.open = 1'b1;
        node_wdata.parent = {cur_row_q, cur_col_q};
        node_wdata.g = ng;
        if (!node_rd.closed && !blk_rd) begin
          if (!node_rd.open) begin
            node_we = 1'b1;
            node_wdata.f = ng + CostW'(hdist);
          end else if (node_rd.g > ng) begin
            node_we = 1'b1;
            node_wdata.f = ng + (node_rd.f - node_rd.g);
          end
        end
        k_d = k_q + 2'd1;
      end
      S_SCAN: begin
        node_raddr = sc_idx_q;
        pv_d = 1'b1;
        sc_idx_d = sc_idx_q + CellW'(1);
        if (DimW'(sc_col_q) + DimW'(1) == w_q) begin
          sc_col_d = '0;
          sc_row_d = sc_row_q + CoordW'(1);
        end else begin
          sc_col_d = sc_col_q + CoordW'(1);
        end
      end
      S_PICK: begin
        if (bf_q) begin
          cur_col_d = best_col_q;
          cur_row_d = best_row_q;
          cur_g_d = best_q.g;
          node_we = 1'b1;
          node_waddr = best_idx_q;
          node_wdata = best_q;
          node_wdata.closed = 1'b1;
          closed_n_d = closed_n_q + LimW'(1);
        end
      end
      S_FIN: found_d = at_goal;
      S_TR_CHK: begin
        if (!((cur_col_q != s_col_q || cur_row_q != s_row_q) && pc_q < MaxExp)) begin
          done_d = 1'b1;
          wx_d = '0;
          wy_d = '0;
        end
      end
      S_TR_WR: begin
        path_we = 1'b1;
        pc_d = pc_q + LimW'(1);
        cur_row_d = node_rd.parent[CellW-1:CoordW];
        cur_col_d = node_rd.parent[CoordW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      found_q <= 1'b0;
      pc_q    <= '0;
      pv_q    <= 1'b0;
      bf_q    <= 1'b0;
      clr_q   <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      found_q <= found_d;
      pc_q    <= pc_d;
      pv_q    <= pv_d;
      bf_q    <= bf_d;
      clr_q   <= clr_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d; h_q <= h_d; lim_q <= lim_d;
    s_col_q <= s_col_d; s_row_q <= s_row_d; g_col_q <= g_col_d; g_row_q <= g_row_d;
    cur_col_q <= cur_col_d; cur_row_q <= cur_row_d; cur_g_q <= cur_g_d;
    closed_n_q <= closed_n_d;
    nb_idx_q <= nb_idx_d; nb_col_q <= nb_col_d; nb_row_q <= nb_row_d;
    p_idx_q <= p_idx_d; p_col_q <= p_col_d; p_row_q <= p_row_d;
    rd_ok_q <= rd_ok_d; wx_q <= wx_d; wy_q <= wy_d;
    best_idx_q <= best_idx_d; best_col_q <= best_col_d; best_row_q <= best_row_d;
    best_q <= best_d;
    sc_col_q <= sc_col_d; sc_row_q <= sc_row_d;
    sc_idx_q <= sc_idx_d;
  end

  gap_ram #(.Width($bits(node_t)), .Depth(Cells)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .raddr_i (node_raddr),
    .rdata_o (node_rd_raw)
  );

  gap_ram #(.Width(1), .Depth(Cells)) u_blk_ram (
    .clk_i   (clk_i),
    .we_i    (blk_we),
    .waddr_i (blk_waddr),
    .wdata_i (cell_blocked_i),
    .raddr_i (blk_raddr),
    .rdata_o (blk_rd)
  );

  gap_ram #(.Width(CellW), .Depth(PathDep)) u_path_ram (
    .clk_i   (clk_i),
    .we_i    (path_we),
    .waddr_i (path_waddr),
    .wdata_i (path_wdata),
    .raddr_i (path_raddr),
    .rdata_o (path_rd)
  );

  assign busy           = state_q != S_IDLE;
  assign done_o         = done_q;
  assign goal_reached_o = found_q;
  assign path_length_o  = pc_q;
  assign waypoint_x_o   = wx_q;
  assign waypoint_y_o   = wy_q;
endmodule
`default_nettype wire

// ===== rtl/gap_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "grid_astar_path_search_assert.svh"
module gap_chk
  import gap_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [1:0]  command_i,
  input wire logic        done_o,
  input wire logic [10:0] path_length_o
);
  `GAP_ASSERT_NEXT(a_load_answers, start && !busy && command_i == CMD_LOAD, done_o)
  `GAP_ASSERT_NEXT(a_search_busy, start && !busy && command_i == CMD_SEARCH, busy && !done_o)
  `GAP_ASSERT_NOW(a_done_idle, done_o, !busy)
  `GAP_ASSERT_NOW(a_len_bound, 1'b1, path_length_o <= MaxExp)
endmodule

bind grid_astar_path_search gap_chk u_gap_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .command_i     (command_i),
  .done_o        (done_o),
  .path_length_o (path_length_o)
);
`default_nettype wire

// ===== tb/grid_astar_path_search_tb.sv =====
`timescale 1ns / 1ps
module grid_astar_path_search_tb;
  import gap_pkg::*;

  localparam int unsigned StallLimit = 200000;

  typedef struct packed {
    cmd_e        cmd;
    logic [11:0] idx;
    logic        blk;
    logic [15:0] sx;
    logic [15:0] sy;
    logic [15:0] gx;
    logic [15:0] gy;
    logic [9:0]  pos;
  } cmd_word_t;

  typedef struct packed {
    logic        found;
    logic [10:0] len;
    logic [5:0]  wx;
    logic [5:0]  wy;
  } path_reply_t;

  typedef struct packed {
    cmd_word_t   word;
    logic        typed;
    path_reply_t want;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] command_i = '0;
  logic [11:0] cell_index_i = '0;
  logic cell_blocked_i = 1'b0;
  logic [15:0] start_x_i = '0, start_y_i = '0, goal_x_i = '0, goal_y_i = '0;
  logic [9:0] path_position_i = '0;
  logic done_o, goal_reached_o;
  logic [10:0] path_length_o;
  logic [5:0] waypoint_x_o, waypoint_y_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [10:0] cfg_data_i = '0;

  grid_astar_path_search dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // model state
  int unsigned cfg_w = 64, cfg_h = 64, cfg_lim = 1024;
  bit   map_blk [Cells];
  bit   map_written [Cells];
  bit   is_closed [Cells];
  bit   is_open [Cells];
  int   parent_of [Cells];
  int   g_cost [Cells];
  int   f_cost [Cells];
  int   open_n;
  logic [11:0] route [PathDep];
  int   route_n;
  bit   found_flag;

  path_reply_t replies_due [$];
  int   mismatches;
  int   words_sent;
  int   stall_cycles;
  bit   no_gaps;

  function automatic int clamp_dim(int unsigned v);
    return (v < 1) ? 1 : ((v > 64) ? 64 : v);
  endfunction

  function automatic int pix_to_cell(int unsigned pix, int dim);
    return (pix / 32 > dim - 1) ? dim - 1 : pix / 32;
  endfunction

  function automatic int cell_gap(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic path_reply_t astar_step(cmd_word_t it);
    path_reply_t r;
    int w, h, lim, cells, src, dst, cur, nclosed, gc, gr, col, row, n, ng, best, bestf, hh;
    r = '0;
    case (it.cmd)
      CMD_LOAD: map_blk[it.idx] = it.blk;
      CMD_SEARCH: begin
        w = clamp_dim(cfg_w);
        h = clamp_dim(cfg_h);
        lim = (cfg_lim > 1024) ? 1024 : cfg_lim;
        cells = w * h;
        for (int i = 0; i < Cells; i++) begin
          is_closed[i] = 0;
          is_open[i] = 0;
        end
        open_n = 0;
        route_n = 0;
        gc = pix_to_cell(it.gx, w);
        gr = pix_to_cell(it.gy, h);
        src = pix_to_cell(it.sy, h) * w + pix_to_cell(it.sx, w);
        dst = gr * w + gc;
        g_cost[src] = 0;
        f_cost[src] = 0;
        parent_of[src] = src;
        is_closed[src] = 1;
        nclosed = 1;
        cur = src;
        while (nclosed < lim && cur != dst) begin
          col = cur % w;
          row = cur / w;
          for (int k = 0; k < 4; k++) begin
            n = -1;
            if (k == 0 && col + 1 < w) n = cur + 1;
            if (k == 1 && col != 0) n = cur - 1;
            if (k == 2 && row + 1 < h) n = cur + w;
            if (k == 3 && row != 0) n = cur - w;
            if (n < 0) continue;
            if (is_closed[n] || map_blk[n]) continue;
            ng = g_cost[cur] + 1;
            if (!is_open[n]) begin
              if (open_n >= Cells) continue;
              parent_of[n] = cur;
              g_cost[n] = ng;
              f_cost[n] = ng + cell_gap(n % w, gc) + cell_gap(n / w, gr);
              is_open[n] = 1;
              open_n++;
            end else if (g_cost[n] > ng) begin
              hh = f_cost[n] - g_cost[n];
              parent_of[n] = cur;
              g_cost[n] = ng;
              f_cost[n] = ng + hh;
            end
          end
          if (open_n == 0) break;
          best = cells;
          bestf = 0;
          for (int k = 0; k < cells; k++)
            if (is_open[k] && !is_closed[k] && (best == cells || f_cost[k] < bestf)) begin
              best = k;
              bestf = f_cost[k];
            end
          if (best == cells) break;
          cur = best;
          open_n--;
          is_closed[cur] = 1;
          nclosed++;
        end
        found_flag = (cur == dst);
        while (cur != src && route_n < PathDep) begin
          route[route_n] = {6'(cur / w), 6'(cur % w)};
          route_n++;
          cur = parent_of[cur];
        end
      end
      CMD_READ: if (it.pos < route_n) begin
        r.wx = route[route_n - 1 - it.pos][5:0];
        r.wy = route[route_n - 1 - it.pos][11:6];
      end
      default: ;
    endcase
    r.found = found_flag;
    r.len = 11'(route_n);
    return r;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : check_replies
    path_reply_t w;
    if (rst_ni && done_o) begin
      if (replies_due.size() == 0) report("unexpected word", 1, 0);
      else begin
        w = replies_due.pop_front();
        if (goal_reached_o !== w.found) report("goal_reached", goal_reached_o, w.found);
        if (path_length_o !== w.len) report("path_length", path_length_o, w.len);
        if (waypoint_x_o !== w.wx) report("waypoint_x", waypoint_x_o, w.wx);
        if (waypoint_y_o !== w.wy) report("waypoint_y", waypoint_y_o, w.wy);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("[grid_astar_path_search] ERROR");
        $finish;
      end
    end
  end

  task automatic issue(input cmd_word_t it, input bit typed, input path_reply_t want);
    path_reply_t r;
    if (!no_gaps && $urandom_range(99) < 50) begin
      @(negedge clk_i);
      start = 1'b0;
    end
    @(negedge clk_i);
    start = 1'b1;
    command_i = it.cmd;
    cell_index_i = it.idx;
    cell_blocked_i = it.blk;
    start_x_i = it.sx;
    start_y_i = it.sy;
    goal_x_i = it.gx;
    goal_y_i = it.gy;
    path_position_i = it.pos;
    do @(posedge clk_i); while (busy);
    if (it.cmd == CMD_LOAD) map_written[it.idx] = 1;
    r = astar_step(it);
    replies_due.push_back(typed ? want : r);
    words_sent++;
  endtask

  function automatic cmd_word_t noise_word();
    cmd_word_t it;
    it = cmd_word_t'($bits(cmd_word_t)'({$urandom, $urandom, $urandom}));
    return it;
  endfunction

  task automatic settle();
    @(negedge clk_i);
    start = 1'b0;
    wait (replies_due.size() == 0);
    do @(posedge clk_i); while (busy);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(input reg_e idx, input logic [10:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    case (idx)
      REG_WIDTH:  cfg_w = data & 7'h7f;
      REG_HEIGHT: cfg_h = data & 7'h7f;
      REG_LIMIT:  cfg_lim = data;
      default: ;
    endcase
  endtask

  task automatic fill_map(input int pct_blocked);
    cmd_word_t it;
    for (int c = 0; c < clamp_dim(cfg_w) * clamp_dim(cfg_h); c++)
      if (!map_written[c]) begin
        it = noise_word();
        it.cmd = CMD_LOAD;
        it.idx = 12'(c);
        it.blk = ($urandom_range(99) < pct_blocked);
        issue(it, 1'b0, '0);
      end
  endtask

  task automatic setup(input int w, input int h, input int lim);
    settle();
    cfg_write(REG_WIDTH, 11'(w));
    cfg_write(REG_HEIGHT, 11'(h));
    cfg_write(REG_LIMIT, 11'(lim));
  endtask

  plan_row_t plan [] = '{
    '{'{CMD_READ,   12'd0,    1'b0, 16'd0,     16'd0,     16'd0,     16'd0,     10'd0},
      1'b1, '{1'b0, 11'd0, 6'd0, 6'd0}},
    '{'{CMD_SEARCH, 12'd0,    1'b0, 16'd5,     16'd7,     16'd20,    16'd31,    10'd0},
      1'b1, '{1'b1, 11'd0, 6'd0, 6'd0}},
    '{'{CMD_READ,   12'd0,    1'b0, 16'd0,     16'd0,     16'd0,     16'd0,     10'd0},
      1'b1, '{1'b1, 11'd0, 6'd0, 6'd0}},
    '{'{CMD_SEARCH, 12'd0,    1'b0, 16'd0,     16'd0,     16'd127,   16'd127,   10'd0},
      1'b0, '0},
    '{'{CMD_READ,   12'd0,    1'b0, 16'd0,     16'd0,     16'd0,     16'd0,     10'd0},
      1'b0, '0},
    '{'{CMD_READ,   12'd0,    1'b0, 16'd0,     16'd0,     16'd0,     16'd0,     10'd5},
      1'b0, '0},
    '{'{CMD_READ,   12'd0,    1'b0, 16'd0,     16'd0,     16'd0,     16'd0,     10'd1023},
      1'b1, '{1'b1, 11'd6, 6'd0, 6'd0}},
    '{'{CMD_LOAD,   12'd4095, 1'b1, 16'd0,     16'd0,     16'd0,     16'd0,     10'd0},
      1'b1, '{1'b1, 11'd6, 6'd0, 6'd0}},
    '{'{CMD_LOAD,   12'd5,    1'b1, 16'd0,     16'd0,     16'd0,     16'd0,     10'd0},
      1'b0, '0},
    '{'{CMD_LOAD,   12'd6,    1'b1, 16'd0,     16'd0,     16'd0,     16'd0,     10'd0},
      1'b0, '0},
    '{'{CMD_LOAD,   12'd9,    1'b1, 16'd0,     16'd0,     16'd0,     16'd0,     10'd0},
      1'b0, '0},
    '{'{CMD_SEARCH, 12'd0,    1'b0, 16'd0,     16'd0,     16'd65535, 16'd65535, 10'd0},
      1'b0, '0},
    '{'{CMD_READ,   12'd0,    1'b0, 16'd0,     16'd0,     16'd0,     16'd0,     10'd0},
      1'b0, '0},
    '{'{CMD_READ,   12'd0,    1'b0, 16'd0,     16'd0,     16'd0,     16'd0,     10'd2},
      1'b0, '0},
    '{'{CMD_LOAD,   12'd15,   1'b1, 16'd0,     16'd0,     16'd0,     16'd0,     10'd0},
      1'b0, '0},
    '{'{CMD_SEARCH, 12'd0,    1'b0, 16'd0,     16'd0,     16'd96,    16'd96,    10'd0},
      1'b0, '0},
    '{'{CMD_READ,   12'd0,    1'b0, 16'd0,     16'd0,     16'd0,     16'd0,     10'd1},
      1'b0, '0},
    '{'{CMD_NONE,   12'd3,    1'b1, 16'd0,     16'd0,     16'd0,     16'd0,     10'd0},
      1'b0, '0},
    '{'{CMD_SEARCH, 12'd0,    1'b0, 16'd32,    16'd32,    16'd0,     16'd0,     10'd0},
      1'b0, '0},
    '{'{CMD_LOAD,   12'd15,   1'b0, 16'd0,     16'd0,     16'd0,     16'd0,     10'd0},
      1'b0, '0},
    '{'{CMD_SEARCH, 12'd0,    1'b0, 16'd0,     16'd127,   16'd127,   16'd0,     10'd0},
      1'b0, '0},
    '{'{CMD_READ,   12'd0,    1'b0, 16'd0,     16'd0,     16'd0,     16'd0,     10'd3},
      1'b0, '0}
  };

  int phase_cfg [][3] = '{
    '{8, 8, 1024}, '{64, 1, 2047}, '{0, 127, 0}, '{127, 2, 1024}, '{5, 7, 3},
    '{8, 8, 20}, '{1, 64, 1024}, '{6, 6, 1}, '{7, 5, 1024}
  };

  initial begin : stimulus
    cmd_word_t it;
    int w, h, pick, p;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: 4x4 grid, filled free, then some cells blocked by the plan
    issue(plan[0].word, plan[0].typed, plan[0].want);
    setup(4, 4, 1024);
    fill_map(0);
    for (int i = 1; i < plan.size(); i++) issue(plan[i].word, plan[i].typed, plan[i].want);

    p = 0;
    while (words_sent < 550) begin
      if (p < phase_cfg.size()) setup(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2]);
      else setup($urandom_range(2, 9), $urandom_range(2, 9),
                 ($urandom_range(3) == 0) ? $urandom_range(1, 30) : 1024);
      p++;
      w = clamp_dim(cfg_w);
      h = clamp_dim(cfg_h);
      fill_map(25);
      for (int i = 0; i < 50; i++) begin
        no_gaps = (p == 4);
        it = noise_word();
        pick = $urandom_range(99);
        if (pick < 14) begin
          it.cmd = CMD_SEARCH;
          if ($urandom_range(99) < 85) begin
            it.sx = 16'($urandom_range(w * 32 - 1));
            it.sy = 16'($urandom_range(h * 32 - 1));
            it.gx = 16'($urandom_range(w * 32 - 1));
            it.gy = 16'($urandom_range(h * 32 - 1));
          end
        end else if (pick < 50) begin
          it.cmd = CMD_LOAD;
          if ($urandom_range(99) < 70) it.idx = 12'($urandom_range(w * h - 1));
          it.blk = ($urandom_range(99) < 30);
        end else if (pick < 96) begin
          it.cmd = CMD_READ;
          if ($urandom_range(99) < 70)
            it.pos = 10'($urandom_range((route_n + 1 > 1023) ? 1023 : route_n + 1));
        end else it.cmd = CMD_NONE;
        issue(it, 1'b0, '0);
      end
      no_gaps = 0;
    end

    settle();
    if (mismatches == 0) $display("[grid_astar_path_search] OK");
    else $display("[grid_astar_path_search] ERROR");
    $finish;
  end
endmodule

// ===== grid_astar_path_search.f =====
+incdir+rtl
rtl/gap_pkg.sv
rtl/gap_ram.sv
rtl/grid_astar_path_search.sv
rtl/gap_chk.sv
tb/grid_astar_path_search_tb.sv
